FILE: rtl/iale_pkg.sv
// Shared types, codes and constants of the indexed array list engine.
`default_nettype none

package iale_pkg;

  // Field widths of the command and result channels
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned ENTRY_W  = VAL_W + 1;

  // Default list capacity
  localparam int unsigned DEPTH_DEF = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_START      = 3'd0,
    CMD_APPEND     = 3'd1,
    CMD_OVERWRITE  = 3'd2,
    CMD_READ       = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_INS_AFTER  = 3'd5,
    CMD_INS_BEFORE = 3'd6,
    CMD_COUNT      = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_STARTED = 2'd1,
    ST_BOUNDS      = 2'd2,
    ST_FULL        = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_PUT,
    S_DONE
  } state_e;

  // Store and pointer operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND,
    OP_OVERWRITE,
    OP_READ,
    OP_DN_INIT,
    OP_DN_STEP,
    OP_UP_INIT,
    OP_UP_STEP,
    OP_PUT
  } dp_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    capture;
    dp_op_e  op;
    cnt_op_e cnt;
    logic    set_started;
    logic    res_load;
    status_e res_status;
    logic    res_from_mem;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic started;
    logic in_range;
    logic full;
    logic dn_more;
    logic up_more;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/iale_if.sv
// Command and result channel interfaces of the indexed array list engine.
`default_nettype none

interface iale_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [iale_pkg::CMD_W-1:0]   command;
  logic        [iale_pkg::IDX_W-1:0]   index;
  logic                                kind;
  logic signed [iale_pkg::VAL_W-1:0]   item_value;

  modport source (output valid, command, index, kind, item_value, input ready);
  modport sink   (input valid, command, index, kind, item_value, output ready);
endinterface

interface iale_res_if;
  logic                                 valid;
  logic                                 ready;
  logic        [iale_pkg::STATUS_W-1:0] status;
  logic                                 out_kind;
  logic signed [iale_pkg::VAL_W-1:0]    out_value;
  logic        [iale_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_kind, out_value, entry_count, input ready);
  modport sink   (input valid, status, out_kind, out_value, entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/iale_datapath.sv
// Datapath: entry store, count, shift pointer, result and output registers.
`default_nettype none

module iale_datapath #(
  parameter int unsigned DEPTH = iale_pkg::DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire iale_pkg::dp_cmd_t                   dp_cmd_i,
  output iale_pkg::dp_status_t                     dp_status_o,
  input  wire logic        [iale_pkg::CMD_W-1:0]   command_i,
  input  wire logic        [iale_pkg::IDX_W-1:0]   index_i,
  input  wire logic                                kind_i,
  input  wire logic signed [iale_pkg::VAL_W-1:0]   item_value_i,
  output logic             [iale_pkg::STATUS_W-1:0] status_o,
  output logic                                     out_kind_o,
  output logic signed      [iale_pkg::VAL_W-1:0]   out_value_o,
  output logic             [iale_pkg::COUNT_W-1:0] entry_count_o
);
  import iale_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  // Captured command
  cmd_e              cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic              kind_q;
  logic [VAL_W-1:0]  val_q;

  // List state
  logic [ENTRY_W-1:0] store_q [DEPTH];
  logic [CW-1:0]      count_q, count_d;
  logic               started_q;

  // Shift machinery
  logic [CW-1:0]      ptr_q, ptr_m1, pos, idx_c;
  logic [ENTRY_W-1:0] rd_data_q;
  logic               wr_pend_q;
  logic [AW-1:0]      wr_addr_q;

  // Store port controls
  logic               we, re;
  logic [AW-1:0]      wa, ra;
  logic [ENTRY_W-1:0] wd, new_entry;

  // Result and output
  status_e            res_status_q, out_status_q;
  logic               res_kind_q;
  logic [VAL_W-1:0]   res_val_q;
  logic               out_kind_q;
  logic [VAL_W-1:0]   out_val_q;
  logic [COUNT_W-1:0] out_count_q;

  // Symbols keep only their low byte
  assign new_entry = {kind_q, kind_q ? VAL_W'(val_q[SYM_W-1:0]) : val_q};
  assign idx_c     = CW'(idx_q);
  assign ptr_m1    = ptr_q - CW'(1);
  assign pos       = (cmd_q == CMD_INS_AFTER) ? idx_c + CW'(1) : idx_c;

  assign dp_status_o.cmd      = cmd_q;
  assign dp_status_o.started  = started_q;
  assign dp_status_o.in_range = KW'(idx_q) < KW'(count_q);
  assign dp_status_o.full     = (count_q == DEPTH_CNT);
  assign dp_status_o.dn_more  = (ptr_q < count_q);
  assign dp_status_o.up_more  = (ptr_q > pos);

  // Latch the transferred command
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q  <= cmd_e'(command_i);
      idx_q  <= index_i;
      kind_q <= kind_i;
      val_q  <= item_value_i;
    end
  end

  // Select store write and read ports
  always_comb begin
    we = 1'b0;
    wa = wr_addr_q;
    wd = rd_data_q;
    re = 1'b0;
    ra = '0;
    if (wr_pend_q) begin
      we = 1'b1;
    end
    case (dp_cmd_i.op)
      OP_APPEND: begin
        we = 1'b1;
        wa = count_q[AW-1:0];
        wd = new_entry;
      end
      OP_OVERWRITE: begin
        we = 1'b1;
        wa = AW'(idx_q);
        wd = new_entry;
      end
      OP_READ: begin
        re = 1'b1;
        ra = AW'(idx_q);
      end
      OP_DN_STEP: begin
        re = 1'b1;
        ra = ptr_q[AW-1:0];
      end
      OP_UP_STEP: begin
        re = 1'b1;
        ra = ptr_m1[AW-1:0];
      end
      OP_PUT: begin
        we = 1'b1;
        wa = ptr_q[AW-1:0];
        wd = new_entry;
      end
      default: begin
      end
    endcase
  end

  // Entry store with registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= store_q[ra];
    end
  end

  // Queue the write half of a shift step for the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= (dp_cmd_i.op == OP_DN_STEP) || (dp_cmd_i.op == OP_UP_STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == OP_DN_STEP) begin
      wr_addr_q <= ptr_m1[AW-1:0];
    end else if (dp_cmd_i.op == OP_UP_STEP) begin
      wr_addr_q <= ptr_q[AW-1:0];
    end
  end

  // Advance the shift pointer
  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      OP_DN_INIT: ptr_q <= idx_c + CW'(1);
      OP_UP_INIT: ptr_q <= count_q;
      OP_DN_STEP: ptr_q <= ptr_q + CW'(1);
      OP_UP_STEP: ptr_q <= ptr_m1;
      default:    ptr_q <= ptr_q;
    endcase
  end

  // Entry count and started flag
  always_comb begin
    case (dp_cmd_i.cnt)
      CNT_CLEAR: count_d = '0;
      CNT_INC:   count_d = count_q + CW'(1);
      CNT_DEC:   count_d = count_q - CW'(1);
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      started_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (dp_cmd_i.set_started) begin
        started_q <= 1'b1;
      end
    end
  end

  // Hold the result until the output register is free
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.res_load) begin
      res_status_q <= dp_cmd_i.res_status;
      res_kind_q   <= dp_cmd_i.res_from_mem ? rd_data_q[ENTRY_W-1] : 1'b0;
      res_val_q    <= dp_cmd_i.res_from_mem ? rd_data_q[VAL_W-1:0] : '0;
    end
    if (dp_cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_kind_q   <= res_kind_q;
      out_val_q    <= res_val_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign status_o      = out_status_q;
  assign out_kind_o    = out_kind_q;
  assign out_value_o   = out_val_q;
  assign entry_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above capacity");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> !(dp_cmd_i.op == OP_APPEND || dp_cmd_i.op == OP_OVERWRITE ||
                    dp_cmd_i.op == OP_PUT))
    else $error("shift write collides with entry write");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  a_up_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.op == OP_UP_STEP) |-> (ptr_q > pos && ptr_q < DEPTH_CNT))
    else $error("upward shift outside the list");

endmodule

`default_nettype wire

FILE: rtl/iale_ctrl.sv
// Controller: sequences command evaluation, shifts and result transfer.
`default_nettype none

module iale_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output iale_pkg::dp_cmd_t         dp_cmd_o,
  input  wire iale_pkg::dp_status_t dp_status_i
);
  import iale_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;

  // State register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (dp_cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d                 = state_q;
    in_ready_o              = 1'b0;
    dp_cmd_o.capture        = 1'b0;
    dp_cmd_o.op             = OP_NONE;
    dp_cmd_o.cnt            = CNT_HOLD;
    dp_cmd_o.set_started    = 1'b0;
    dp_cmd_o.res_load       = 1'b0;
    dp_cmd_o.res_status     = ST_OK;
    dp_cmd_o.res_from_mem   = 1'b0;
    dp_cmd_o.out_load       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.capture = 1'b1;
          state_d          = S_EVAL;
        end
      end
      S_EVAL: begin
        dp_cmd_o.res_load = 1'b1;
        state_d           = S_DONE;
        if (dp_status_i.cmd == CMD_START) begin
          dp_cmd_o.cnt         = CNT_CLEAR;
          dp_cmd_o.set_started = 1'b1;
        end else if (!dp_status_i.started) begin
          dp_cmd_o.res_status = ST_NOT_STARTED;
        end else begin
          case (dp_status_i.cmd)
            CMD_APPEND: begin
              if (dp_status_i.full) begin
                dp_cmd_o.res_status = ST_FULL;
              end else begin
                dp_cmd_o.op  = OP_APPEND;
                dp_cmd_o.cnt = CNT_INC;
              end
            end
            CMD_OVERWRITE: begin
              if (!dp_status_i.in_range) begin
                dp_cmd_o.res_status = ST_BOUNDS;
              end else begin
                dp_cmd_o.op = OP_OVERWRITE;
              end
            end
            CMD_READ: begin
              if (!dp_status_i.in_range) begin
                dp_cmd_o.res_status = ST_BOUNDS;
              end else begin
                dp_cmd_o.op       = OP_READ;
                dp_cmd_o.res_load = 1'b0;
                state_d           = S_READ;
              end
            end
            CMD_REMOVE: begin
              if (!dp_status_i.in_range) begin
                dp_cmd_o.res_status = ST_BOUNDS;
              end else begin
                dp_cmd_o.op       = OP_DN_INIT;
                dp_cmd_o.res_load = 1'b0;
                state_d           = S_SHIFT_DN;
              end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (!dp_status_i.in_range) begin
                dp_cmd_o.res_status = ST_BOUNDS;
              end else if (dp_status_i.full) begin
                dp_cmd_o.res_status = ST_FULL;
              end else begin
                dp_cmd_o.op       = OP_UP_INIT;
                dp_cmd_o.res_load = 1'b0;
                state_d           = S_SHIFT_UP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        dp_cmd_o.res_load     = 1'b1;
        dp_cmd_o.res_from_mem = 1'b1;
        state_d               = S_DONE;
      end
      S_SHIFT_DN: begin
        // move one entry down per cycle, then drop the count
        if (dp_status_i.dn_more) begin
          dp_cmd_o.op = OP_DN_STEP;
        end else begin
          dp_cmd_o.cnt      = CNT_DEC;
          dp_cmd_o.res_load = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        // move one entry up per cycle; the last move drains before the put
        if (dp_status_i.up_more) begin
          dp_cmd_o.op = OP_UP_STEP;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        dp_cmd_o.op       = OP_PUT;
        dp_cmd_o.cnt      = CNT_INC;
        dp_cmd_o.res_load = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.out_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/indexed_array_list_engine_core.sv
// Indexed array list engine: bounded ordered list with shifting insert and remove.
//
// Channels: cmd_i carries one command (start, append, overwrite, read, remove,
// insert after, insert before, count) with index, kind and item value; res_o
// returns exactly one result per command: status, kind and value of an entry
// read, and the entry count after the command. Both use valid/ready; a
// transfer happens on a rising edge with valid and ready high.
// Sequencing: one command at a time. Start, append, overwrite, count and every
// failing command go through the evaluate and done states, a read through
// evaluate, read and done. Remove shifts the entries above index i down, and an
// insert shifts entries up and then puts the new one, since the store has one
// write and one read port and moves one entry per cycle.
// A new command is taken once the previous result sits in the output register.
// Reset: list empty and not started; every command but start answers not
// started until the first start. The store needs no clearing pass.
// Stall: while res_o is stalled, one finished result is held in the output
// register and the next command is executed; its result waits until the
// output register drains.
`default_nettype none

module indexed_array_list_engine_core #(
  parameter int unsigned DEPTH = iale_pkg::DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iale_cmd_if.sink  cmd_i,
  iale_res_if.source res_o
);
  import iale_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  iale_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_status_i (dp_status)
  );

  iale_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .dp_status_o   (dp_status),
    .command_i     (cmd_i.command),
    .index_i       (cmd_i.index),
    .kind_i        (cmd_i.kind),
    .item_value_i  (cmd_i.item_value),
    .status_o      (res_o.status),
    .out_kind_o    (res_o.out_kind),
    .out_value_o   (res_o.out_value),
    .entry_count_o (res_o.entry_count)
  );

endmodule

`default_nettype wire
